/* rtl/ppes_pkg.sv */
// Package for the particle pool: sizes, register codes, pool entry type and saturating adders.
`default_nettype none

package ppes_pkg;

  localparam int POOL_SIZE = 64;
  localparam int PTR_W     = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int CNT_W     = $clog2(POOL_SIZE + 1);

  localparam int POS_W  = 20;
  localparam int TIME_W = 24;
  localparam int DT_W   = 16;
  localparam int OFS_W  = 6;
  localparam int PROD_W = POS_W + 1;

  localparam logic [TIME_W-1:0] LIFE_SPAN_RST     = 24'd65536;
  localparam logic [TIME_W-1:0] EMIT_INTERVAL_RST = 24'd6554;

  typedef enum logic [2:0] {
    REG_EMIT_X,
    REG_EMIT_Y,
    REG_START_VEL_X,
    REG_START_VEL_Y,
    REG_ACCEL_X,
    REG_ACCEL_Y,
    REG_LIFE_SPAN,
    REG_EMIT_INTERVAL
  } cfg_reg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] vel_x;
    logic signed [POS_W-1:0] vel_y;
    logic [TIME_W-1:0]       age;
  } entry_t;

  // a + b, clamped to the 20 bit signed range
  function automatic logic signed [POS_W-1:0] add_sat20(input logic signed [POS_W-1:0] a,
                                                        input logic signed [PROD_W-1:0] b);
    logic signed [POS_W+1:0] s;
    s = {{2{a[POS_W-1]}}, a} + {b[PROD_W-1], b};
    if (s[POS_W+1:POS_W-1] == 3'b000 || s[POS_W+1:POS_W-1] == 3'b111) begin
      return s[POS_W-1:0];
    end else if (s[POS_W+1]) begin
      return {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      return {1'b0, {(POS_W-1){1'b1}}};
    end
  endfunction

  // a + b, clamped at the 24 bit maximum
  function automatic logic [TIME_W-1:0] add_sat24(input logic [TIME_W-1:0] a,
                                                  input logic [DT_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {{(TIME_W-DT_W+1){1'b0}}, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/particle_pool_euler_step.sv */
// Particle pool advanced once per time tick request, with a shared multiplier and a sequencer.
//
// Input channel (in_valid/in_ready): one request per tick carries delta_time and the
// random emission offsets. in_ready is high only while the block is idle.
// Output channel (out_valid/out_ready): one result per particle handled, holding its
// position before the move; last marks the final result of the tick. An empty pool
// gives no result.
// Config channel (cfg_valid/cfg_ready): always ready; write only while idle.
// Sequence: for n particles handled (n <= live count), the single 20x17 multiplier sets
// the steps: two products per tick for acceleration, then two per particle (velocity
// x and y) followed by an update step that also writes a surviving particle back to
// the pool memory.
// Results pass through one output register; when the receiver stalls, the sequencer
// holds in its update cycle until the register frees up.
// Reset: live count and emit timer clear, config registers take their reset values.
// The pool memory is not cleared; only slots below the live count are ever read.
`default_nettype none

module particle_pool_euler_step (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  input  wire logic [ppes_pkg::DT_W-1:0]               delta_time,
  input  wire logic signed [ppes_pkg::OFS_W-1:0]       offset_x,
  input  wire logic signed [ppes_pkg::OFS_W-1:0]       offset_y,
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output logic signed [ppes_pkg::POS_W-1:0]            pos_x,
  output logic signed [ppes_pkg::POS_W-1:0]            pos_y,
  output logic                                         last,
  input  wire logic                                    cfg_valid,
  output logic                                         cfg_ready,
  input  wire logic [2:0]                              cfg_index,
  input  wire logic [ppes_pkg::TIME_W-1:0]             cfg_data
);
  import ppes_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT,
    S_ACCY,
    S_ACCD,
    S_MVX,
    S_MVY,
    S_UPD
  } state_t;

  state_t state;

  logic signed [POS_W-1:0] emit_x, emit_y, start_vel_x, start_vel_y, accel_x, accel_y;
  logic [TIME_W-1:0]       life_span, emit_interval;

  logic [TIME_W-1:0]        emit_timer;
  logic [CNT_W-1:0]         live;
  logic [CNT_W-1:0]         idx;
  logic [DT_W-1:0]          dt;
  logic signed [OFS_W-1:0]  ox, oy;
  logic                     emit_go;
  logic signed [PROD_W-1:0] prod, dvx, dvy;
  logic signed [POS_W-1:0]  pnx;

  entry_t mem [POOL_SIZE];
  entry_t rdata;

  logic              rd_en, wr_en;
  logic [PTR_W-1:0]  rd_addr, wr_addr;
  entry_t            wr_data;

  logic signed [POS_W-1:0]        mul_a;
  logic signed [POS_W+DT_W:0]     mul_full;
  logic [TIME_W-1:0]              timer_next;
  logic                           timer_over;
  entry_t                         upd;
  entry_t                         new_part;
  logic                           remove;
  logic                           can_push;
  logic [CNT_W-1:0]               live_less1;
  logic [CNT_W-1:0]               idx_plus1;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // shared multiplier, floored back to Q16.4
  always_comb begin
    unique case (state)
      S_EMIT:  mul_a = accel_x;
      S_ACCY:  mul_a = accel_y;
      S_MVX:   mul_a = rdata.vel_x;
      default: mul_a = rdata.vel_y;
    endcase
  end
  assign mul_full = mul_a * $signed({1'b0, dt});

  assign timer_next = add_sat24(emit_timer, delta_time);
  assign timer_over = (timer_next > emit_interval);

  assign live_less1 = live - CNT_W'(1);
  assign idx_plus1  = idx + CNT_W'(1);
  assign can_push   = !out_valid || out_ready;

  always_comb begin
    new_part.pos_x = add_sat20(emit_x, {{(PROD_W-OFS_W-4){ox[OFS_W-1]}}, ox, 4'b0000});
    new_part.pos_y = add_sat20(emit_y, {{(PROD_W-OFS_W-4){oy[OFS_W-1]}}, oy, 4'b0000});
    new_part.vel_x = start_vel_x;
    new_part.vel_y = start_vel_y;
    new_part.age   = '0;

    upd.pos_x = pnx;
    upd.pos_y = add_sat20(rdata.pos_y, prod);
    upd.vel_x = add_sat20(rdata.vel_x, dvx);
    upd.vel_y = add_sat20(rdata.vel_y, dvy);
    upd.age   = add_sat24(rdata.age, dt);
    remove    = (upd.age > life_span);
  end

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = live[PTR_W-1:0];
    wr_data = new_part;
    unique case (state)
      S_EMIT: begin
        wr_en = emit_go;
      end
      S_ACCD: begin
        rd_en = (live != '0);
      end
      S_UPD: begin
        if (can_push) begin
          if (remove) begin
            rd_en   = (idx < live_less1);
            rd_addr = live_less1[PTR_W-1:0];
          end else begin
            wr_en   = 1'b1;
            wr_addr = idx[PTR_W-1:0];
            wr_data = upd;
            rd_en   = (idx_plus1 < live);
            rd_addr = idx_plus1[PTR_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_x        <= '0;
      emit_y        <= '0;
      start_vel_x   <= '0;
      start_vel_y   <= '0;
      accel_x       <= '0;
      accel_y       <= '0;
      life_span     <= LIFE_SPAN_RST;
      emit_interval <= EMIT_INTERVAL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_EMIT_X:        emit_x        <= cfg_data[POS_W-1:0];
        REG_EMIT_Y:        emit_y        <= cfg_data[POS_W-1:0];
        REG_START_VEL_X:   start_vel_x   <= cfg_data[POS_W-1:0];
        REG_START_VEL_Y:   start_vel_y   <= cfg_data[POS_W-1:0];
        REG_ACCEL_X:       accel_x       <= cfg_data[POS_W-1:0];
        REG_ACCEL_Y:       accel_y       <= cfg_data[POS_W-1:0];
        REG_LIFE_SPAN:     life_span     <= cfg_data;
        REG_EMIT_INTERVAL: emit_interval <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      emit_timer <= '0;
      live       <= '0;
      idx        <= '0;
      out_valid  <= 1'b0;
      emit_go    <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_UPD) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            dt         <= delta_time;
            ox         <= offset_x;
            oy         <= offset_y;
            emit_timer <= timer_over ? '0 : timer_next;
            emit_go    <= timer_over && (live < CNT_W'(POOL_SIZE));
            state      <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            live <= live + CNT_W'(1);
          end
          prod  <= mul_full[POS_W+DT_W:DT_W];
          state <= S_ACCY;
        end
        S_ACCY: begin
          dvx   <= prod;
          prod  <= mul_full[POS_W+DT_W:DT_W];
          state <= S_ACCD;
        end
        S_ACCD: begin
          dvy   <= prod;
          idx   <= '0;
          state <= (live != '0) ? S_MVX : S_IDLE;
        end
        S_MVX: begin
          prod  <= mul_full[POS_W+DT_W:DT_W];
          state <= S_MVY;
        end
        S_MVY: begin
          pnx   <= add_sat20(rdata.pos_x, prod);
          prod  <= mul_full[POS_W+DT_W:DT_W];
          state <= S_UPD;
        end
        S_UPD: begin
          if (can_push) begin
            out_valid <= 1'b1;
            pos_x     <= rdata.pos_x;
            pos_y     <= rdata.pos_y;
            if (remove) begin
              // last live particle takes this slot and is handled next
              live  <= live_less1;
              last  <= !(idx < live_less1);
              state <= (idx < live_less1) ? S_MVX : S_IDLE;
            end else begin
              idx   <= idx_plus1;
              last  <= !(idx_plus1 < live);
              state <= (idx_plus1 < live) ? S_MVX : S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live <= CNT_W'(POOL_SIZE))
    else $error("live count above pool size");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MVX || state == S_MVY || state == S_UPD) |-> idx < live)
    else $error("slot index outside live particles");

  a_emit_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && emit_go) |=> live == $past(live) + CNT_W'(1))
    else $error("emission did not add a particle");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_UPD)
    else $error("result raised outside update cycle");

endmodule

`default_nettype wire
